// ----- sv/md5_pkg.sv -----
// MD5 engine package: beat types, constants and round tables.
package md5_pkg;

	typedef struct packed {
		logic       end_of_message;
		logic       byte_present;
		logic [7:0] data_byte;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] digest_high;
		logic [63:0] digest_low;
	} out_beat_t;

	// controller -> datapath
	typedef struct packed {
		logic       init;      // load IV, clear count
		logic       wr_byte;   // write byte into buffer, count += 8
		logic [7:0] wr_data;
		logic       round_go;  // execute one round
		logic       rnd_start; // latch working vars from chaining
		logic       fold;      // add working vars into chaining
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [5:0]  pos;
		logic [63:0] bit_count;
	} dp_sts_t;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hEFCDAB89;
	localparam logic [31:0] INIT_C = 32'h98BADCFE;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [5:0]  LEN_POS = 6'd56;
	localparam logic [5:0]  LAST_POS = 6'd63;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		unique case (i)
			6'd0: k = 32'hD76AA478; 6'd1: k = 32'hE8C7B756;
			6'd2: k = 32'h242070DB; 6'd3: k = 32'hC1BDCEEE;
			6'd4: k = 32'hF57C0FAF; 6'd5: k = 32'h4787C62A;
			6'd6: k = 32'hA8304613; 6'd7: k = 32'hFD469501;
			6'd8: k = 32'h698098D8; 6'd9: k = 32'h8B44F7AF;
			6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
			6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193;
			6'd14: k = 32'hA679438E; 6'd15: k = 32'h49B40821;
			6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
			6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA;
			6'd20: k = 32'hD62F105D; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
			6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6;
			6'd26: k = 32'hF4D50D87; 6'd27: k = 32'h455A14ED;
			6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
			6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A;
			6'd32: k = 32'hFFFA3942; 6'd33: k = 32'h8771F681;
			6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
			6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9;
			6'd38: k = 32'hF6BB4B60; 6'd39: k = 32'hBEBFBC70;
			6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
			6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05;
			6'd44: k = 32'hD9D4D039; 6'd45: k = 32'hE6DB99E5;
			6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
			6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97;
			6'd50: k = 32'hAB9423A7; 6'd51: k = 32'hFC93A039;
			6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
			6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1;
			6'd56: k = 32'h6FA87E4F; 6'd57: k = 32'hFE2CE6E0;
			6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
			6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235;
			6'd62: k = 32'h2AD7D2BB; 6'd63: k = 32'hEB86D391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] round_s(input logic [5:0] i);
		logic [4:0] s;
		unique case ({i[5:4], i[1:0]})
			4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
			4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
			4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'hA: s = 5'd16; 4'hB: s = 5'd23;
			4'hC: s = 5'd6;  4'hD: s = 5'd10; 4'hE: s = 5'd15; 4'hF: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// message word index for round i
	function automatic logic [3:0] round_g(input logic [5:0] i);
		logic [3:0] g;
		unique case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'(4'(i[3:0] * 4'd5) + 4'd1);
			2'd2: g = 4'(4'(i[3:0] * 4'd3) + 4'd5);
			2'd3: g = 4'(i[3:0] * 4'd7);
			default: g = 4'd0;
		endcase
		return g;
	endfunction

endpackage

// ----- sv/md5_datapath.sv -----
// MD5 datapath: block buffer, bit count, chaining words and the round unit.
module md5_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  md5_pkg::dp_cmd_t     cmd,
	input  logic [5:0]           rnd,
	output md5_pkg::dp_sts_t     sts,
	output logic [127:0]         digest
);
	// block buffer as 16 little-endian message words
	logic [31:0] buf_q [16];
	logic [63:0] count_q;
	logic [31:0] h_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] f, w, sum, rot;
	logic [3:0]  g;
	logic [4:0]  s;

	assign sts.pos = count_q[8:3];
	assign sts.bit_count = count_q;
	assign digest = {h_q[3], h_q[2], h_q[1], h_q[0]};

	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			buf_q[count_q[8:5]][{count_q[4:3], 3'd0} +: 8] <= cmd.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			h_q[0] <= md5_pkg::INIT_A;
			h_q[1] <= md5_pkg::INIT_B;
			h_q[2] <= md5_pkg::INIT_C;
			h_q[3] <= md5_pkg::INIT_D;
		end else if (cmd.init) begin
			count_q <= '0;
			h_q[0] <= md5_pkg::INIT_A;
			h_q[1] <= md5_pkg::INIT_B;
			h_q[2] <= md5_pkg::INIT_C;
			h_q[3] <= md5_pkg::INIT_D;
		end else begin
			if (cmd.wr_byte) begin
				count_q <= count_q + 64'd8;
			end
			if (cmd.fold) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
			end
		end
	end

	always_comb begin
		unique case (rnd[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			2'd3: f = c_q ^ (b_q | ~d_q);
			default: f = '0;
		endcase
		g = md5_pkg::round_g(rnd);
		s = md5_pkg::round_s(rnd);
		w = buf_q[g];
		sum = a_q + f + md5_pkg::round_k(rnd) + w;
		rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
	end

	always_ff @(posedge clk) begin
		if (cmd.rnd_start) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
		end else if (cmd.round_go) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rot;
		end
	end
endmodule

// ----- sv/md5_ctrl.sv -----
// MD5 controller: input handshake, padding sequencer and round counter.
module md5_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  md5_pkg::in_beat_t    in_beat,
	output logic                 out_valid,
	input  logic                 out_stall,
	output md5_pkg::dp_cmd_t     cmd,
	output logic [5:0]           rnd,
	input  md5_pkg::dp_sts_t     sts
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_FOLD  = 3'd3;
	localparam logic [2:0] ST_PAD   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]  state_q;
	logic [5:0]  rnd_q;
	logic        fin_q;      // finishing message
	logic        pad80_q;    // 0x80 byte still owed
	logic        len_blk_q;  // current block carries the length
	logic [63:0] len_q;
	logic [2:0]  lidx_q;
	logic        accept;
	logic        wr;
	logic [7:0]  wdat;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign rnd = rnd_q;

	always_comb begin
		wr = 1'b0;
		wdat = in_beat.data_byte;
		if (accept && in_beat.byte_present) begin
			wr = 1'b1;
		end else if (state_q == ST_PAD) begin
			wr = 1'b1;
			if (pad80_q) begin
				wdat = md5_pkg::PAD_BYTE;
			end else if (len_blk_q && sts.pos >= md5_pkg::LEN_POS) begin
				wdat = len_q[{lidx_q, 3'd0} +: 8];
			end else begin
				wdat = 8'h00;
			end
		end
		cmd.wr_byte = wr;
		cmd.wr_data = wdat;
		cmd.init = (state_q == ST_OUT) && !out_stall;
		cmd.rnd_start = (state_q == ST_START);
		cmd.round_go = (state_q == ST_ROUND);
		cmd.fold = (state_q == ST_FOLD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
			fin_q <= 1'b0;
			pad80_q <= 1'b0;
			len_blk_q <= 1'b0;
			lidx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fin_q <= in_beat.end_of_message;
						pad80_q <= in_beat.end_of_message;
						len_blk_q <= 1'b0;
						lidx_q <= '0;
						if (in_beat.byte_present && sts.pos == md5_pkg::LAST_POS) begin
							state_q <= ST_START;
						end else if (in_beat.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad80_q <= 1'b0;
					// length fits only if 0x80 lands before byte 56
					if (pad80_q && sts.pos < md5_pkg::LEN_POS) begin
						len_blk_q <= 1'b1;
					end
					if (!pad80_q && len_blk_q && sts.pos >= md5_pkg::LEN_POS) begin
						lidx_q <= lidx_q + 3'd1;
					end
					if (sts.pos == md5_pkg::LAST_POS) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					rnd_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (len_blk_q) begin
						state_q <= ST_OUT;
					end else begin
						// one more block: zeros, then the length
						len_blk_q <= 1'b1;
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						fin_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// message length captured once the final data byte is in
	always_ff @(posedge clk) begin
		if (accept) begin
			len_q <= sts.bit_count + (in_beat.byte_present ? 64'd8 : 64'd0);
		end
	end
endmodule

// ----- sv/md5_hash_engine.sv -----
// MD5 hash engine top level.
// Input channel in_valid/in_stall carries one beat: a message byte, a
// byte-present flag and an end-of-message flag. Output channel
// out_valid/out_stall carries the 128-bit digest as two 64-bit words,
// digest byte 0 in bits 7:0 of digest_low.
// Throughput: bytes that do not complete a 64-byte block are taken one per
// cycle while in_stall is low. The 64th byte of a block starts the
// compression, which runs one round per cycle in a single shared round
// unit; in_stall is high throughout.
// End of message: padding bytes are written one per cycle (up to 64,
// more when the length does not fit in the current block), followed by
// one or two compressions, then the digest is held on the output until
// taken; out_valid stays high and nothing is accepted while out_stall is
// high.
// Reset loads the MD5 initial chaining values and clears the bit count;
// the block buffer holds no reset value. After the digest beat the
// engine returns to that initial state.
module md5_hash_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  md5_pkg::in_beat_t    in_beat,
	output logic                 out_valid,
	input  logic                 out_stall,
	output md5_pkg::out_beat_t   out_beat
);
	md5_pkg::dp_cmd_t cmd;
	md5_pkg::dp_sts_t sts;
	logic [5:0]       rnd;
	logic [127:0]     digest;

	md5_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_beat,
		.out_valid, .out_stall, .cmd, .rnd, .sts
	);

	md5_datapath u_dp (
		.clk, .arst_n, .cmd, .rnd, .sts, .digest
	);

	assign out_beat.digest_low  = digest[63:0];
	assign out_beat.digest_high = digest[127:64];
endmodule

// ----- sv/md5_hash_engine_checker.sv -----
// Port-level checker for the MD5 engine, bound to the top level.
module md5_hash_engine_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input md5_pkg::out_beat_t   out_beat
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while digest pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_beat))
		else $error("digest changed while stalled");
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid) else $error("digest repeated");
	a_no_quick_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid) else $error("digest right after input");
endmodule

bind md5_hash_engine md5_hash_engine_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_beat
);
